[hdl/mi3_pkg.sv]
package mi3_pkg;

  localparam int EW            = 32;   // element width
  localparam int CW            = 64;   // cofactor width
  localparam int DW            = 97;   // signed determinant width
  localparam int AW            = 96;   // determinant magnitude width
  localparam int QW            = 32;   // quotient bits, one per divider stage
  localparam int NEL           = 9;    // elements in a matrix
  localparam int FRAC_BITS_DEF = 16;

  typedef logic [EW-1:0] elem_t;
  typedef logic [CW-1:0] cof_t;
  typedef logic [DW-1:0] det_t;

  typedef struct packed {
    logic [AW-1:0] rem;   // partial remainder, below the divisor while not saturated
    logic [QW-1:0] nlo;   // numerator bits still to be shifted in
    logic [QW-1:0] q;
    logic          sat;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic [AW-1:0]        d;
    logic                 sing;
    lane_t [NEL-1:0]      lane;
  } div_t;

endpackage

[hdl/mi3_cof.sv]
module mi3_cof (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  mi3_pkg::elem_t [8:0]          m,
  output mi3_pkg::cof_t  [8:0]          cof,
  output mi3_pkg::elem_t [2:0]          mrow
);
  import mi3_pkg::*;

  logic signed [CW-1:0] prod_a [NEL];
  logic signed [CW-1:0] prod_b [NEL];
  elem_t [2:0]          mrow1;

  // element indexes by row: 0..2 first row, 3..5 second, 6..8 third
  function automatic logic [3:0] ia(input int k);
    logic [3:0] r;
    unique case (k)
      0: r = 4'd4;
      1: r = 4'd2;
      2: r = 4'd1;
      3: r = 4'd5;
      4: r = 4'd0;
      5: r = 4'd2;
      6: r = 4'd3;
      7: r = 4'd1;
      8: r = 4'd0;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] ib(input int k);
    logic [3:0] r;
    unique case (k)
      0: r = 4'd8;
      1: r = 4'd7;
      2: r = 4'd5;
      3: r = 4'd6;
      4: r = 4'd8;
      5: r = 4'd3;
      6: r = 4'd7;
      7: r = 4'd6;
      8: r = 4'd4;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] ic(input int k);
    logic [3:0] r;
    unique case (k)
      0: r = 4'd5;
      1: r = 4'd1;
      2: r = 4'd2;
      3: r = 4'd3;
      4: r = 4'd2;
      5: r = 4'd0;
      6: r = 4'd4;
      7: r = 4'd0;
      8: r = 4'd1;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] id(input int k);
    logic [3:0] r;
    unique case (k)
      0: r = 4'd7;
      1: r = 4'd8;
      2: r = 4'd4;
      3: r = 4'd8;
      4: r = 4'd6;
      5: r = 4'd5;
      6: r = 4'd6;
      7: r = 4'd7;
      8: r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < NEL; k++) begin
        prod_a[k] <= $signed(m[ia(k)]) * $signed(m[ib(k)]);
        prod_b[k] <= $signed(m[ic(k)]) * $signed(m[id(k)]);
      end
      mrow1 <= m[2:0];
    end
  end

  // difference of two products stays inside 64 bits
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < NEL; k++) begin
        cof[k] <= prod_a[k] - prod_b[k];
      end
      mrow <= mrow1;
    end
  end

endmodule

[hdl/mi3_det.sv]
module mi3_det (
  input  logic                          clk,
  input  logic [2:0]                    en,
  input  mi3_pkg::cof_t  [8:0]          cof,
  input  mi3_pkg::elem_t [2:0]          mrow,
  output mi3_pkg::cof_t  [8:0]          cof_out,
  output mi3_pkg::det_t                 det
);
  import mi3_pkg::*;

  logic signed [CW-1:0] ph [3];
  logic signed [CW:0]   pl [3];
  det_t                 term [3];
  cof_t [8:0]           cof_a;
  cof_t [8:0]           cof_b;

  // 32 x 64 product split into high and low halves of the cofactor
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        ph[k] <= $signed(mrow[k]) * $signed(cof[3*k][CW-1:QW]);
        pl[k] <= $signed(mrow[k]) * $signed({1'b0, cof[3*k][QW-1:0]});
      end
      cof_a <= cof;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        term[k] <= {ph[k][CW-1], ph[k], 32'd0} + {{(DW-CW-1){pl[k][CW]}}, pl[k]};
      end
      cof_b <= cof_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      det     <= term[0] + term[1] + term[2];
      cof_out <= cof_b;
    end
  end

endmodule

[hdl/mi3_prep.sv]
module mi3_prep #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  mi3_pkg::cof_t  [8:0]          cof,
  input  mi3_pkg::det_t                 det,
  output mi3_pkg::div_t                 dv
);
  import mi3_pkg::*;

  localparam int NW = CW + 2 * FRAC_BITS;

  logic [NEL-1:0][CW-1:0] absc;
  logic [NEL-1:0][NW-1:0] num;
  logic [NEL-1:0][AW-1:0] r0;
  logic [AW-1:0]          dabs;
  det_t                   dneg;
  div_t                   dv_next;

  always_comb begin
    dneg = -det;
    dabs = det[DW-1] ? dneg[AW-1:0] : det[AW-1:0];
    dv_next.d    = dabs;
    dv_next.sing = (det == '0);
    for (int k = 0; k < NEL; k++) begin
      absc[k] = cof[k][CW-1] ? (~cof[k] + 1'b1) : cof[k];
      num[k]  = NW'(absc[k]) << (2 * FRAC_BITS);
      r0[k]   = AW'(num[k][NW-1:QW]);
      // a top part at or above the divisor means the quotient needs more than 32 bits
      dv_next.lane[k].sat = (r0[k] >= dabs);
      dv_next.lane[k].rem = dv_next.lane[k].sat ? '0 : r0[k];
      dv_next.lane[k].nlo = num[k][QW-1:0];
      dv_next.lane[k].q   = '0;
      dv_next.lane[k].neg = cof[k][CW-1] ^ det[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv <= dv_next;
    end
  end

endmodule

[hdl/mi3_divstep.sv]
module mi3_divstep (
  input  logic                          clk,
  input  logic                          en,
  input  mi3_pkg::div_t                 din,
  output mi3_pkg::div_t                 dout
);
  import mi3_pkg::*;

  logic [NEL-1:0][AW:0] t;
  logic [NEL-1:0][AW:0] diff;
  logic [NEL-1:0]       ge;
  div_t                 dout_next;

  // one restoring quotient bit for every lane
  always_comb begin
    dout_next = din;
    for (int k = 0; k < NEL; k++) begin
      t[k]    = {din.lane[k].rem, din.lane[k].nlo[QW-1]};
      diff[k] = t[k] - {1'b0, din.d};
      ge[k]   = (t[k] >= {1'b0, din.d});
      dout_next.lane[k].rem = ge[k] ? diff[k][AW-1:0] : t[k][AW-1:0];
      dout_next.lane[k].nlo = {din.lane[k].nlo[QW-2:0], 1'b0};
      dout_next.lane[k].q   = {din.lane[k].q[QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

[hdl/matrix3x3_inverse.sv]
// 3x3 matrix inverse by adjugate, signed fixed point with FRAC_BITS fraction bits.
// input channel: in_valid / in_ready carry one matrix m11..m33 per item.
// output channel: out_valid / out_ready carry r11..r33 and singular per item.
// each item gives exactly one result, in order.
// pipeline of 39 register stages: two for the cofactor products and differences,
// three for the determinant, one for magnitudes and the overflow check, 32 divider
// stages (one quotient bit each, nine lanes side by side) and one output stage.
// one item is accepted every cycle while the output is taken.
// quotients are rounded toward zero and saturate to the 32-bit range.
// a zero determinant gives singular high and all elements zero.
// when out_ready is low, items still move up while any later stage is empty and hold once
// all later stages are full, so in_ready stays high until every stage holds an item.
// reset clears all stage valid bits; items in flight are dropped.
module matrix3x3_inverse #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mi3_pkg::elem_t       m11,
  input  mi3_pkg::elem_t       m12,
  input  mi3_pkg::elem_t       m13,
  input  mi3_pkg::elem_t       m21,
  input  mi3_pkg::elem_t       m22,
  input  mi3_pkg::elem_t       m23,
  input  mi3_pkg::elem_t       m31,
  input  mi3_pkg::elem_t       m32,
  input  mi3_pkg::elem_t       m33,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mi3_pkg::elem_t       r11,
  output mi3_pkg::elem_t       r12,
  output mi3_pkg::elem_t       r13,
  output mi3_pkg::elem_t       r21,
  output mi3_pkg::elem_t       r22,
  output mi3_pkg::elem_t       r23,
  output mi3_pkg::elem_t       r31,
  output mi3_pkg::elem_t       r32,
  output mi3_pkg::elem_t       r33,
  output logic                 singular
);
  import mi3_pkg::*;

  localparam int DIV0 = 6;
  localparam int NS   = DIV0 + QW + 1;

  logic [NS-1:0]    v;
  logic [NS-1:0]    en;
  elem_t [8:0]      m;
  cof_t  [8:0]      cof1;
  elem_t [2:0]      mrow;
  cof_t  [8:0]      cof2;
  det_t             det;
  div_t             dq [QW+1];
  elem_t [8:0]      r;
  elem_t [8:0]      r_next;
  logic             singular_next;

  // a stage takes a new item when empty or when its successor moves on
  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  assign m = {m33, m32, m31, m23, m22, m21, m13, m12, m11};

  mi3_cof u_cof (
    .clk  (clk),
    .en   (en[1:0]),
    .m    (m),
    .cof  (cof1),
    .mrow (mrow)
  );

  mi3_det u_det (
    .clk     (clk),
    .en      (en[4:2]),
    .cof     (cof1),
    .mrow    (mrow),
    .cof_out (cof2),
    .det     (det)
  );

  mi3_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk (clk),
    .en  (en[DIV0-1]),
    .cof (cof2),
    .det (det),
    .dv  (dq[0])
  );

  for (genvar g = 0; g < QW; g++) begin : g_div
    mi3_divstep u_step (
      .clk  (clk),
      .en   (en[DIV0+g]),
      .din  (dq[g]),
      .dout (dq[g+1])
    );
  end

  always_comb begin
    singular_next = dq[QW].sing;
    for (int k = 0; k < NEL; k++) begin
      if (dq[QW].sing) begin
        r_next[k] = '0;
      end else if (dq[QW].lane[k].neg) begin
        r_next[k] = (dq[QW].lane[k].sat || dq[QW].lane[k].q[QW-1]) ?
                    {1'b1, {(EW-1){1'b0}}} : (~dq[QW].lane[k].q + 1'b1);
      end else begin
        r_next[k] = (dq[QW].lane[k].sat || dq[QW].lane[k].q[QW-1]) ?
                    {1'b0, {(EW-1){1'b1}}} : dq[QW].lane[k].q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      r        <= r_next;
      singular <= singular_next;
    end
  end

  assign r11 = r[0];
  assign r12 = r[1];
  assign r13 = r[2];
  assign r21 = r[3];
  assign r22 = r[4];
  assign r23 = r[5];
  assign r31 = r[6];
  assign r32 = r[7];
  assign r33 = r[8];

endmodule

[verif/tb_matrix3x3_inverse.sv]
`timescale 1ns / 100ps

module tb_matrix3x3_inverse;
  import mi3_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 39;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_RANDOM = 600;
  localparam logic [31:0] POS_SAT = 32'h7fffffff;
  localparam logic [31:0] NEG_SAT = 32'h80000000;
  localparam logic [31:0] ONE_Q = 32'h00010000;

  typedef logic signed [31:0] mat_t [9];

  typedef struct {
    logic [31:0] el [9];
    logic        sing;
  } inv_t;

  typedef struct {
    mat_t m;
    logic known;
    inv_t res;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  elem_t m11, m12, m13, m21, m22, m23, m31, m32, m33;
  elem_t r11, r12, r13, r21, r22, r23, r31, r32, r33;
  logic singular;

  inv_t pending_inv [$];
  int fail_count = 0;
  int checked = 0;
  int singular_seen = 0;
  int sat_seen = 0;
  int idle_cycles = 0;

  matrix3x3_inverse uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .m11(m11), .m12(m12), .m13(m13), .m21(m21), .m22(m22), .m23(m23),
    .m31(m31), .m32(m32), .m33(m33),
    .out_valid(out_valid), .out_ready(out_ready),
    .r11(r11), .r12(r12), .r13(r13), .r21(r21), .r22(r22), .r23(r23),
    .r31(r31), .r32(r32), .r33(r33), .singular(singular)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // adjugate, exact determinant, truncating divide with saturation
  function automatic inv_t invert_matrix(mat_t m);
    logic signed [63:0] c [9];
    logic signed [127:0] det, num, q;
    inv_t r;
    c[0] = 64'(m[4]) * m[8] - 64'(m[5]) * m[7];
    c[1] = 64'(m[2]) * m[7] - 64'(m[1]) * m[8];
    c[2] = 64'(m[1]) * m[5] - 64'(m[2]) * m[4];
    c[3] = 64'(m[5]) * m[6] - 64'(m[3]) * m[8];
    c[4] = 64'(m[0]) * m[8] - 64'(m[2]) * m[6];
    c[5] = 64'(m[2]) * m[3] - 64'(m[0]) * m[5];
    c[6] = 64'(m[3]) * m[7] - 64'(m[4]) * m[6];
    c[7] = 64'(m[1]) * m[6] - 64'(m[0]) * m[7];
    c[8] = 64'(m[0]) * m[4] - 64'(m[1]) * m[3];
    det = 128'(m[0]) * c[0] + 128'(m[1]) * c[3] + 128'(m[2]) * c[6];
    r.sing = (det == 0);
    for (int k = 0; k < 9; k++) begin
      if (r.sing) begin
        r.el[k] = '0;
      end else begin
        num = 128'(c[k]) <<< (2 * FRAC);
        q = num / det;
        if (q > 128'sh7fffffff) r.el[k] = POS_SAT;
        else if (q < -128'sh80000000) r.el[k] = NEG_SAT;
        else r.el[k] = q[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_element();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? POS_SAT : NEG_SAT;
      2: return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC;
      3: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
    endcase
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    int s;
    for (int k = 0; k < 9; k++) m[k] = pick_element();
    case ($urandom_range(0, 7))
      0: begin
        // rank deficient: copy a row onto the next one
        s = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) m[3 * ((s + 1) % 3) + k] = m[3 * s + k];
      end
      1: begin
        // small off-diagonal entries
        for (int k = 0; k < 9; k++) if (k % 4 != 0) m[k] = $urandom_range(0, 255);
      end
      2: for (int k = 0; k < 9; k++) m[k] = $urandom;
      default: ;
    endcase
    return m;
  endfunction

  task automatic drive_matrix(mat_t m);
    in_valid <= 1'b1;
    m11 <= m[0]; m12 <= m[1]; m13 <= m[2];
    m21 <= m[3]; m22 <= m[4]; m23 <= m[5];
    m31 <= m[6]; m32 <= m[7]; m33 <= m[8];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_matrix(mat_t m);
    pending_inv.push_back(invert_matrix(m));
    drive_matrix(m);
  endtask

  // rising edge: acceptance of results, checking, watchdog
  always @(posedge clk) begin
    inv_t e;
    logic [31:0] got [9];
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, pending_inv.size());
        $display("Some tests failed");
        $finish;
      end
      if (out_valid && out_ready) begin
        got = '{r11, r12, r13, r21, r22, r23, r31, r32, r33};
        if (pending_inv.size() == 0) begin
          $display("%0t: result item with nothing outstanding", $time);
          fail_count++;
        end else begin
          e = pending_inv.pop_front();
          checked++;
          if (singular) singular_seen++;
          for (int k = 0; k < 9; k++) begin
            if (got[k] == POS_SAT || got[k] == NEG_SAT) sat_seen++;
            if (got[k] !== e.el[k]) begin
              $display("%0t: r%0d%0d expected %h actual %h", $time, k / 3 + 1, k % 3 + 1,
                       e.el[k], got[k]);
              fail_count++;
            end
          end
          if (singular !== e.sing) begin
            $display("%0t: singular expected %b actual %b", $time, e.sing, singular);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver stalls in its own pattern: always ready, mostly ready, mostly stalled, alternating
  initial begin
    int mode;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    row_t dir_rows [$];
    row_t rw;
    inv_t z, idn, e;
    mat_t m;
    int burst;
    int gap;
    in_valid = 1'b0;
    {m11, m12, m13, m21, m22, m23, m31, m32, m33} = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    z.sing = 1'b1;
    for (int k = 0; k < 9; k++) z.el[k] = '0;
    idn.sing = 1'b0;
    for (int k = 0; k < 9; k++) idn.el[k] = (k % 4 == 0) ? ONE_Q : '0;

    // all zero, identity, all-ones rank one, extremes
    rw.m = '{default: '0}; rw.known = 1; rw.res = z; dir_rows.push_back(rw);
    rw.m = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q}; rw.res = idn; dir_rows.push_back(rw);
    rw.m = '{default: 32'hffffffff}; rw.res = z; dir_rows.push_back(rw);
    rw.m = '{default: POS_SAT}; rw.res = z; dir_rows.push_back(rw);
    rw.m = '{default: NEG_SAT}; rw.res = z; dir_rows.push_back(rw);
    rw.known = 0;
    rw.m = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; dir_rows.push_back(rw);            // saturates high
    rw.m = '{-1, 0, 0, 0, -1, 0, 0, 0, -1}; dir_rows.push_back(rw);         // saturates low
    rw.m = '{NEG_SAT, 0, 0, 0, NEG_SAT, 0, 0, 0, NEG_SAT}; dir_rows.push_back(rw);
    rw.m = '{POS_SAT, 0, 0, 0, POS_SAT, 0, 0, 0, POS_SAT}; dir_rows.push_back(rw);
    rw.m = '{NEG_SAT, POS_SAT, 0, POS_SAT, NEG_SAT, 0, 0, 0, 1}; dir_rows.push_back(rw);
    rw.m = '{2 * ONE_Q, ONE_Q, 0, ONE_Q, 3 * ONE_Q, ONE_Q, 0, ONE_Q, 4 * ONE_Q};
    dir_rows.push_back(rw);
    rw.m = '{0, ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, 0, 0}; dir_rows.push_back(rw); // permutation
    rw.m = '{-3 * ONE_Q, 7, 5 * ONE_Q, 11, -ONE_Q, 13, 2, 9, ONE_Q}; dir_rows.push_back(rw);
    rw.m = '{32'h55555555, 32'haaaaaaaa, 3, 32'haaaaaaaa, 32'h55555555, 5, 7, 9, 32'h55555555};
    dir_rows.push_back(rw);

    foreach (dir_rows[i]) begin
      e = dir_rows[i].known ? dir_rows[i].res : invert_matrix(dir_rows[i].m);
      pending_inv.push_back(e);
      drive_matrix(dir_rows[i].m);
    end

    // random part, sender in bursts with gaps
    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++) begin
        m = random_matrix();
        send_matrix(m);
      end
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending_inv.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("checked %0d inverses, %0d singular, %0d saturated elements",
             checked, singular_seen, sat_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
